FILE: design/qte_pkg.sv
// Shared constants, types and tables for the quaternion to Euler angle pipeline.
`default_nettype none

package qte_pkg;

  // Parameter defaults
  localparam int CORDIC_STAGES_DEF  = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;

  // Fixed field and datapath widths
  localparam int IN_W     = 16;  // quaternion component
  localparam int ANG_W    = 27;  // angle accumulator, degrees with 16 fraction bits
  localparam int OUT_W    = 16;  // rounded angle, degrees * 128
  localparam int ROOT_W   = 31;  // Q.30 magnitude, at most 1.0
  localparam int SQ_W     = 64;  // square root working width
  localparam int SQ_STAGES = 32; // one result bit per stage
  localparam int TABLE_LEN = 24;

  // Output limits in degrees * 128
  localparam int OUT_FULL_LIM = 23040;
  localparam int OUT_HALF_LIM = 11520;

  // Half turn in degrees with 16 fraction bits
  localparam int HALF_TURN = 180 * 65536;

  // Width of the atan2 numerator and denominator
  function automatic int vec_width(input int f);
    return ((2 * f > 33) ? 2 * f : 33) + 2;
  endfunction

  // CORDIC x/y width: room for negation and gain
  function automatic int cordic_width(input int f);
    return vec_width(f) + 2;
  endfunction

  // atan(2^-i) in degrees with 16 fraction bits
  function automatic logic [21:0] atan_deg(input int i);
    logic [21:0] r;
    case (i)
      0:       r = 22'd2949120;
      1:       r = 22'd1740967;
      2:       r = 22'd919879;
      3:       r = 22'd466945;
      4:       r = 22'd234379;
      5:       r = 22'd117304;
      6:       r = 22'd58666;
      7:       r = 22'd29335;
      8:       r = 22'd14668;
      9:       r = 22'd7334;
      10:      r = 22'd3667;
      11:      r = 22'd1833;
      12:      r = 22'd917;
      13:      r = 22'd458;
      14:      r = 22'd229;
      15:      r = 22'd115;
      16:      r = 22'd57;
      17:      r = 22'd29;
      18:      r = 22'd14;
      19:      r = 22'd7;
      20:      r = 22'd4;
      21:      r = 22'd2;
      22:      r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  // Pitch side information carried along with the data
  typedef struct packed {
    logic neg;  // asin argument negative
    logic sat;  // asin argument clamped
  } pitch_flags_t;

endpackage

`default_nettype wire

FILE: design/qte_front.sv
// Front end: products, atan2 vectors, asin clamp and the radicand for the cosine.
`default_nettype none

module qte_front #(
  parameter int QUAT_FRAC_BITS = qte_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire logic                                                clk,
  input  wire logic                                                rst,
  input  wire logic                                                en,
  input  wire logic                                                in_valid,
  input  wire logic signed [qte_pkg::IN_W-1:0]                     w,
  input  wire logic signed [qte_pkg::IN_W-1:0]                     x,
  input  wire logic signed [qte_pkg::IN_W-1:0]                     y,
  input  wire logic signed [qte_pkg::IN_W-1:0]                     z,
  output logic                                                     out_valid,
  output logic signed [qte_pkg::vec_width(QUAT_FRAC_BITS)-1:0]     roll_n,
  output logic signed [qte_pkg::vec_width(QUAT_FRAC_BITS)-1:0]     roll_d,
  output logic signed [qte_pkg::vec_width(QUAT_FRAC_BITS)-1:0]     yaw_n,
  output logic signed [qte_pkg::vec_width(QUAT_FRAC_BITS)-1:0]     yaw_d,
  output logic signed [qte_pkg::vec_width(QUAT_FRAC_BITS)-1:0]     pitch_n,
  output qte_pkg::pitch_flags_t                                    flags,
  output logic [qte_pkg::SQ_W-1:0]                                 radicand
);
  import qte_pkg::*;

  localparam int VW = vec_width(QUAT_FRAC_BITS);
  localparam int F2 = 2 * QUAT_FRAC_BITS;
  localparam int PW = 2 * IN_W;
  localparam logic signed [VW-1:0] ONE = VW'(1) <<< F2;

  // Stage 1: products
  logic signed [PW-1:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_xz;
  logic                 v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= w * x;
      p_yz <= y * z;
      p_xx <= x * x;
      p_yy <= y * y;
      p_wz <= w * z;
      p_xy <= x * y;
      p_zz <= z * z;
      p_wy <= w * y;
      p_xz <= x * z;
    end
  end

  // Stage 2: sums, clamp of the asin argument, magnitude to Q.30
  logic signed [VW-1:0] rn_c, rd_c, yn_c, yd_c, s_c, sc_c, pn_c, pm_c;
  logic [VW-1:0]        a_u;
  logic [ROOT_W-1:0]    a30_c;
  logic                 sat_c, neg_c;

  always_comb begin
    rn_c  = (VW'(p_wx) + VW'(p_yz)) <<< 1;
    rd_c  = ONE - ((VW'(p_xx) + VW'(p_yy)) <<< 1);
    yn_c  = (VW'(p_wz) + VW'(p_xy)) <<< 1;
    yd_c  = ONE - ((VW'(p_yy) + VW'(p_zz)) <<< 1);
    s_c   = (VW'(p_wy) - VW'(p_xz)) <<< 1;
    sat_c = 1'b0;
    sc_c  = s_c;
    if (s_c > ONE) begin
      sc_c  = ONE;
      sat_c = 1'b1;
    end else if (s_c < -ONE) begin
      sc_c  = -ONE;
      sat_c = 1'b1;
    end
    neg_c = sc_c < 0;
    a_u   = neg_c ? VW'(-sc_c) : VW'(sc_c);
  end

  generate
    if (F2 >= 30) begin : g_shr
      assign a30_c = ROOT_W'(a_u >> (F2 - 30));
    end else begin : g_shl
      assign a30_c = ROOT_W'(a_u << (30 - F2));
    end
  endgenerate

  assign pm_c = VW'($signed({1'b0, a30_c}));
  assign pn_c = neg_c ? -pm_c : pm_c;

  logic signed [VW-1:0] rn2, rd2, yn2, yd2, pn2;
  logic [ROOT_W-1:0]    a30_2;
  pitch_flags_t         fl2;
  logic                 v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rn2       <= rn_c;
      rd2       <= rd_c;
      yn2       <= yn_c;
      yd2       <= yd_c;
      pn2       <= pn_c;
      a30_2     <= a30_c;
      fl2.neg   <= neg_c;
      fl2.sat   <= sat_c;
    end
  end

  // Stage 3: square of the magnitude, truncated to Q.30
  logic [2*ROOT_W-1:0]  prod;
  logic [ROOT_W-1:0]    sq3;
  logic signed [VW-1:0] rn3, rd3, yn3, yd3, pn3;
  pitch_flags_t         fl3;
  logic                 v3;

  assign prod = (2*ROOT_W)'(a30_2) * (2*ROOT_W)'(a30_2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq3 <= ROOT_W'(prod >> 30);
      rn3 <= rn2;
      rd3 <= rd2;
      yn3 <= yn2;
      yd3 <= yd2;
      pn3 <= pn2;
      fl3 <= fl2;
    end
  end

  // Stage 4: radicand (1 - s^2) in Q.60
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      radicand <= (SQ_W'(1) << 30) - SQ_W'(sq3) << 30;
      roll_n   <= rn3;
      roll_d   <= rd3;
      yaw_n    <= yn3;
      yaw_d    <= yd3;
      pitch_n  <= pn3;
      flags    <= fl3;
    end
  end

endmodule

`default_nettype wire

FILE: design/qte_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module qte_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [qte_pkg::SQ_W-1:0]      radicand,
  output logic                               out_valid,
  output logic [qte_pkg::ROOT_W-1:0]         root
);
  import qte_pkg::*;

  logic [SQ_W-1:0] rem [0:SQ_STAGES];
  logic [SQ_W-1:0] res [0:SQ_STAGES];
  logic            vld [0:SQ_STAGES];

  assign rem[0] = radicand;
  assign res[0] = '0;
  assign vld[0] = in_valid;

  genvar k;
  generate
    for (k = 0; k < SQ_STAGES; k++) begin : g_stage
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
      logic [SQ_W-1:0] trial;

      assign trial = res[k] + BIT;

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k+1] <= 1'b0;
        end else if (en) begin
          vld[k+1] <= vld[k];
        end
      end

      // Restoring step: keep the bit when the trial fits
      always_ff @(posedge clk) begin
        if (en) begin
          if (rem[k] >= trial) begin
            rem[k+1] <= rem[k] - trial;
            res[k+1] <= (res[k] >> 1) + BIT;
          end else begin
            rem[k+1] <= rem[k];
            res[k+1] <= res[k] >> 1;
          end
        end
      end
    end
  endgenerate

  assign out_valid = vld[SQ_STAGES];
  assign root      = ROOT_W'(res[SQ_STAGES]);

endmodule

`default_nettype wire

FILE: design/qte_cordic.sv
// Vectoring CORDIC atan2 pipeline with half-plane fold and output rounding.
`default_nettype none

module qte_cordic #(
  parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF,
  parameter int VW     = qte_pkg::vec_width(qte_pkg::QUAT_FRAC_BITS_DEF),
  parameter int LIM    = qte_pkg::OUT_FULL_LIM
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic signed [VW-1:0]          num,
  input  wire logic signed [VW-1:0]          den,
  output logic                               out_valid,
  output logic signed [qte_pkg::OUT_W-1:0]   angle
);
  import qte_pkg::*;

  localparam int CW = VW + 2;
  localparam int RW = ANG_W - 9;
  localparam logic signed [ANG_W-1:0] HALF = ANG_W'(HALF_TURN);
  localparam logic signed [RW-1:0]    LIM_P = RW'(LIM);
  localparam logic signed [RW-1:0]    LIM_N = -RW'(LIM);

  logic signed [CW-1:0]    xr [0:STAGES];
  logic signed [CW-1:0]    yr [0:STAGES];
  logic signed [ANG_W-1:0] ar [0:STAGES];
  logic                    vr [0:STAGES];

  // Fold the left half plane onto the right one
  always_ff @(posedge clk) begin
    if (rst) begin
      vr[0] <= 1'b0;
    end else if (en) begin
      vr[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (den < 0) begin
        xr[0] <= -CW'(den);
        yr[0] <= -CW'(num);
        ar[0] <= (num >= 0) ? HALF : -HALF;
      end else begin
        xr[0] <= CW'(den);
        yr[0] <= CW'(num);
        ar[0] <= '0;
      end
    end
  end

  // Micro-rotations toward the x axis
  genvar i;
  generate
    for (i = 0; i < STAGES; i++) begin : g_rot
      localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(atan_deg(i));
      logic signed [CW-1:0] xs, ys;

      assign xs = xr[i] >>> i;
      assign ys = yr[i] >>> i;

      always_ff @(posedge clk) begin
        if (rst) begin
          vr[i+1] <= 1'b0;
        end else if (en) begin
          vr[i+1] <= vr[i];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          if (yr[i] > 0) begin
            xr[i+1] <= xr[i] + ys;
            yr[i+1] <= yr[i] - xs;
            ar[i+1] <= ar[i] + ATAN;
          end else if (yr[i] < 0) begin
            xr[i+1] <= xr[i] - ys;
            yr[i+1] <= yr[i] + xs;
            ar[i+1] <= ar[i] - ATAN;
          end else begin
            xr[i+1] <= xr[i];
            yr[i+1] <= yr[i];
            ar[i+1] <= ar[i];
          end
        end
      end
    end
  endgenerate

  // Round to 7 fraction bits and saturate
  logic signed [ANG_W-1:0] biased;
  logic signed [RW-1:0]    rounded;

  assign biased  = ar[STAGES] + ANG_W'(256);
  assign rounded = RW'(biased >>> 9);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vr[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rounded > LIM_P) begin
        angle <= OUT_W'(LIM_P);
      end else if (rounded < LIM_N) begin
        angle <= OUT_W'(LIM_N);
      end else begin
        angle <= OUT_W'(rounded);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/quaternion_to_euler_angles_unit.sv
// Top level: quaternion in, roll/pitch/yaw out, with a two-entry output buffer.
//
// Converts one attitude quaternion (w, x, y, z, signed fixed point with
// QUAT_FRAC_BITS fraction bits) into roll, pitch and yaw in degrees * 128.
// Input channel s_*: one quaternion per beat. Output channel m_*: one set of
// angles per beat, tuser carries the pitch clamp flag.
// From input beat to m_tvalid a quaternion passes 4 front-end stages, 32
// square root stages for the pitch cosine, CORDIC_STAGES + 2 CORDIC stages
// and the output register.
// Throughput is one beat per cycle while the skid register is empty; the pipeline has no loops and the three
// atan2 units run side by side.
// Reset clears every valid bit; data registers are not reset.
// When the receiver stalls, the output register holds its beat and one more
// result lands in the skid register; s_tready then drops and the whole
// pipeline freezes in place until the skid register drains.
`default_nettype none

module quaternion_to_euler_angles_unit #(
  parameter int CORDIC_STAGES  = qte_pkg::CORDIC_STAGES_DEF,
  parameter int QUAT_FRAC_BITS = qte_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // q_scalar, q_i, q_j, q_k (16 bits each)
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // roll_angle[15:0], pitch_angle[30:16],
                                      // yaw_angle[46:31], zero pad[47]
  output logic [0:0]       m_tuser    // pitch_saturated
);
  import qte_pkg::*;

  localparam int VW = vec_width(QUAT_FRAC_BITS);
  localparam int CD = CORDIC_STAGES + 2;  // CORDIC latency
  localparam int RES_W = 49;

  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  // Front end
  logic                 f_valid;
  logic signed [VW-1:0] f_rn, f_rd, f_yn, f_yd, f_pn;
  pitch_flags_t         f_fl;
  logic [SQ_W-1:0]      f_rad;

  qte_front #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_front (
    .clk, .rst, .en,
    .in_valid (s_tvalid),
    .w        (s_tdata[15:0]),
    .x        (s_tdata[31:16]),
    .y        (s_tdata[47:32]),
    .z        (s_tdata[63:48]),
    .out_valid(f_valid),
    .roll_n   (f_rn),
    .roll_d   (f_rd),
    .yaw_n    (f_yn),
    .yaw_d    (f_yd),
    .pitch_n  (f_pn),
    .flags    (f_fl),
    .radicand (f_rad)
  );

  // Pitch cosine
  logic              q_valid;
  logic [ROOT_W-1:0] q_root;

  qte_isqrt u_isqrt (
    .clk, .rst, .en,
    .in_valid (f_valid),
    .radicand (f_rad),
    .out_valid(q_valid),
    .root     (q_root)
  );

  // Delay the other vectors alongside the square root
  logic signed [VW-1:0] d_rn [0:SQ_STAGES-1];
  logic signed [VW-1:0] d_rd [0:SQ_STAGES-1];
  logic signed [VW-1:0] d_yn [0:SQ_STAGES-1];
  logic signed [VW-1:0] d_yd [0:SQ_STAGES-1];
  logic signed [VW-1:0] d_pn [0:SQ_STAGES-1];
  logic                 d_sat [0:SQ_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      d_rn[0]  <= f_rn;
      d_rd[0]  <= f_rd;
      d_yn[0]  <= f_yn;
      d_yd[0]  <= f_yd;
      d_pn[0]  <= f_pn;
      d_sat[0] <= f_fl.sat;
      for (int k = 1; k < SQ_STAGES; k++) begin
        d_rn[k]  <= d_rn[k-1];
        d_rd[k]  <= d_rd[k-1];
        d_yn[k]  <= d_yn[k-1];
        d_yd[k]  <= d_yd[k-1];
        d_pn[k]  <= d_pn[k-1];
        d_sat[k] <= d_sat[k-1];
      end
    end
  end

  // Clamp flag follows the CORDIC latency
  logic c_sat [0:CD-1];

  always_ff @(posedge clk) begin
    if (en) begin
      c_sat[0] <= d_sat[SQ_STAGES-1];
      for (int k = 1; k < CD; k++) begin
        c_sat[k] <= c_sat[k-1];
      end
    end
  end

  // Three atan2 units
  logic                    r_valid, p_valid, y_valid;
  logic signed [OUT_W-1:0] r_ang, p_ang, y_ang;
  logic signed [VW-1:0]    p_den;

  assign p_den = VW'($signed({1'b0, q_root}));

  qte_cordic #(.STAGES(CORDIC_STAGES), .VW(VW), .LIM(OUT_FULL_LIM)) u_roll (
    .clk, .rst, .en,
    .in_valid (q_valid),
    .num      (d_rn[SQ_STAGES-1]),
    .den      (d_rd[SQ_STAGES-1]),
    .out_valid(r_valid),
    .angle    (r_ang)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES), .VW(VW), .LIM(OUT_HALF_LIM)) u_pitch (
    .clk, .rst, .en,
    .in_valid (q_valid),
    .num      (d_pn[SQ_STAGES-1]),
    .den      (p_den),
    .out_valid(p_valid),
    .angle    (p_ang)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES), .VW(VW), .LIM(OUT_FULL_LIM)) u_yaw (
    .clk, .rst, .en,
    .in_valid (q_valid),
    .num      (d_yn[SQ_STAGES-1]),
    .den      (d_yd[SQ_STAGES-1]),
    .out_valid(y_valid),
    .angle    (y_ang)
  );

  // Output register plus skid register
  logic [RES_W-1:0] res_new, out_data, skid_data;
  logic             push, take, out_valid;

  assign res_new = {c_sat[CD-1], 1'b0, y_ang, p_ang[14:0], r_ang};
  assign push    = en && r_valid && p_valid && y_valid;
  assign take    = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_data <= res_new;
      end else begin
        out_data <= res_new;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data[47:0];
  assign m_tuser  = out_data[48:48];

`ifndef SYNTHESIS
  // Skid register only fills behind a waiting output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full with empty output register");

  // Skid register drains only on an output beat
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    $past(skid_valid) && !skid_valid && !$past(rst) |-> $past(m_tready))
    else $error("skid register dropped without an output beat");

  // Roll and yaw stay within a half turn
  a_roll_yaw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(out_data[15:0]) <= 16'sd23040 &&
                  $signed(out_data[15:0]) >= -16'sd23040 &&
                  $signed(out_data[46:31]) <= 16'sd23040 &&
                  $signed(out_data[46:31]) >= -16'sd23040)
    else $error("roll or yaw beyond half turn");

  // Pitch stays within a quarter turn
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(out_data[30:16]) <= 15'sd11520 &&
                  $signed(out_data[30:16]) >= -15'sd11520)
    else $error("pitch beyond quarter turn");
`endif

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Testbench for the quaternion to Euler angle unit: directed and random quaternions.
`timescale 1ns / 1ps

module tb;
  import qte_pkg::*;

  typedef struct {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  typedef struct {
    logic [15:0] roll;
    logic [14:0] pitch;
    logic [15:0] yaw;
    logic        sat;
  } euler_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;

  euler_t angles_due[$];
  int     err_count = 0;
  int     beats_in = 0;
  int     beats_out = 0;
  int     sat_seen = 0;
  bit     quiet = 1'b0;   // no idling on either side while set

  quaternion_to_euler_angles_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  // Integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC atan2, degrees with 16 fraction bits
  function automatic longint atan2_deg(longint yv, longint xv);
    longint atan_tbl [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                              58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                              229, 115};
    longint ang, xs, ys;
    ang = 0;
    if (xv < 0) begin
      ang = (yv >= 0) ? 64'sd11796480 : -64'sd11796480;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < 16; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv > 0) begin
        xv = xv + ys; yv = yv - xs; ang = ang + atan_tbl[i];
      end else if (yv < 0) begin
        xv = xv - ys; yv = yv + xs; ang = ang - atan_tbl[i];
      end
    end
    return ang;
  endfunction

  // Round to degrees * 128 and clamp
  function automatic longint round_deg(longint a, longint lim);
    longint r;
    r = (a + 256) >>> 9;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t quat_to_euler(quat_t q);
    longint w, x, y, z, one, s, mag, a30, sq, c30;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    one = 64'sd1 << 28;
    s = 2 * (w * y - x * z);
    e.sat = 1'b0;
    if (s > one) begin
      s = one; e.sat = 1'b1;
    end else if (s < -one) begin
      s = -one; e.sat = 1'b1;
    end
    mag = (s < 0) ? -s : s;
    a30 = mag << 2;
    sq = (a30 * a30) >>> 30;
    c30 = int_sqrt(((64'd1 << 30) - sq) << 30);
    e.roll  = 16'(round_deg(atan2_deg(2 * (w * x + y * z), one - 2 * (x * x + y * y)),
                            OUT_FULL_LIM));
    e.pitch = 15'(round_deg(atan2_deg((s < 0) ? -a30 : a30, c30), OUT_HALF_LIM));
    e.yaw   = 16'(round_deg(atan2_deg(2 * (w * z + x * y), one - 2 * (y * y + z * z)),
                            OUT_FULL_LIM));
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    err_count++;
    $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_out, what, got, want);
  endtask

  // Send one quaternion beat, with an occasional idle stretch first
  task automatic send_quat(quat_t q);
    if (!quiet && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while (!quiet && $urandom_range(99) < 7);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {q.z, q.y, q.x, q.w};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    angles_due.push_back(quat_to_euler(q));
    beats_in++;
    @(negedge clk);
  endtask

  task automatic send_wxyz(int w, int x, int y, int z);
    quat_t q;
    q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
    send_quat(q);
  endtask

  // Receiver stalls
  always @(negedge clk)
    m_tready <= quiet || ($urandom_range(99) >= 7);

  // Result checker
  always @(posedge clk) begin
    euler_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (angles_due.size() == 0) begin
        err_count++;
        $display("MISMATCH unexpected result beat %0d", beats_out);
      end else begin
        e = angles_due.pop_front();
        if (m_tdata[15:0] !== e.roll)
          report_mismatch("roll", $signed(m_tdata[15:0]), $signed(e.roll));
        if (m_tdata[30:16] !== e.pitch)
          report_mismatch("pitch", $signed(m_tdata[30:16]), $signed(e.pitch));
        if (m_tdata[46:31] !== e.yaw)
          report_mismatch("yaw", $signed(m_tdata[46:31]), $signed(e.yaw));
        if (m_tuser[0] !== e.sat)
          report_mismatch("pitch_saturated", m_tuser[0], e.sat);
        if (e.sat) sat_seen++;
      end
      beats_out++;
    end
  end

  // Identity, axis turns, gimbal lock, clamp, left half plane, zero vector, extremes
  task automatic test_directed();
    send_wxyz(16384, 0, 0, 0);
    send_wxyz(0, 0, 0, 0);
    send_wxyz(11585, 11585, 0, 0);
    send_wxyz(11585, 0, 11585, 0);
    send_wxyz(11585, 0, -11585, 0);
    send_wxyz(11585, 0, 0, 11585);
    send_wxyz(0, 16384, 0, 0);
    send_wxyz(0, 0, 0, 16384);
    send_wxyz(0, -16384, 0, 0);
    send_wxyz(8192, 8192, 8192, -8192);    // atan2 of a zero vector for roll
    send_wxyz(32767, 0, 32767, 0);         // asin argument above one
    send_wxyz(32767, 0, -32768, 0);        // asin argument below minus one
    send_wxyz(-32768, -32768, -32768, -32768);
    send_wxyz(32767, 32767, 32767, 32767);
    send_wxyz(-32768, 32767, -32768, 32767);
    send_wxyz(32767, -32768, 32767, -32768);
    send_wxyz(0, 32767, 32767, 0);
    send_wxyz(0, 1, -1, 1);
    send_wxyz(-1, -1, -1, -1);
    send_wxyz(8192, -8192, 8192, 8192);
  endtask

  // Random quaternions with components between -1.0 and 1.0, the first quarter without any idling
  task automatic test_random_unit(int n);
    for (int i = 0; i < n; i++) begin
      quiet = (i < n / 4);
      send_wxyz($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                $urandom_range(32768) - 16384, $urandom_range(32768) - 16384);
    end
    quiet = 1'b0;
  endtask

  // Full-range components, saturating most of the time
  task automatic test_random_full(int n);
    quat_t q;
    for (int i = 0; i < n; i++) begin
      q.w = 16'($urandom); q.x = 16'($urandom); q.y = 16'($urandom); q.z = 16'($urandom);
      send_quat(q);
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_unit(1400);
    test_random_full(600);
    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (angles_due.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (80) @(posedge clk);
    $display("Sent %0d quaternions, checked %0d angle sets, %0d with pitch clamped.",
             beats_in, beats_out, sat_seen);
    if (err_count == 0 && angles_due.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
